>>> rtl/core/stp_pkg.sv
// shared types and codes for the sorted timer pool
// no dependencies
package stp_pkg;

	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_ALLOC = 3'd1;
	localparam logic [2:0] MODE_FREE  = 3'd2;
	localparam logic [2:0] MODE_SET   = 3'd3;
	localparam logic [2:0] MODE_ARM   = 3'd4;

	localparam logic [2:0] KIND_FIRED  = 3'd0;
	localparam logic [2:0] KIND_ALLOC  = 3'd1;
	localparam logic [2:0] KIND_NONE   = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_FULL   = 3'd4;

	localparam logic [1:0] FLAG_FREE  = 2'd0;
	localparam logic [1:0] FLAG_ALLOC = 2'd1;
	localparam logic [1:0] FLAG_RUN   = 2'd2;

	localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;
	localparam int MAX_FIRE = 16;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ALLOC  = 7'b0000010,
		ST_FIRE   = 7'b0000100,
		ST_SHIFT  = 7'b0001000,
		ST_FIND   = 7'b0010000,
		ST_INSERT = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

endpackage

>>> rtl/core/sorted_timeout_timer_pool_unit.sv
// sorted timer pool: item sequencer over a shared deadline comparator
// depends on stp_pkg
//
// usage: one input word per operation on s_axis; tuser holds the mode and
// tdata holds timer_id, delay, payload, destination. results leave on m_axis
// with the kind in tuser, slot, fired_data, fired_destination in tdata and
// tlast on the final word of an item.
// a tick that expires nothing and an unknown mode give no word.
// steps: free, set, a refused arm and a tick that expires nothing are done
// in idle, any word is in the output register the next cycle; allocate scans
// one slot a cycle up to the last slot; arm walks the sorted list one entry a
// cycle to find its place, then shifts the tail one entry a cycle; a tick
// that fires pops one head entry a cycle, waiting while the output register
// is full, and then shifts the survivors down one entry a cycle.
// the fire and find compares share the single compare unit.
// s_axis_tready is low while an item is in work and while a result word waits
// in the output register for a receiver that does not take it.
// a stalled receiver holds the output register and the sequencer waits.
// reset clears the count, the list length and all slot flags; deadline,
// payload and list stores are undefined until written.
module sorted_timeout_timer_pool_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0]
	input  logic [2:0]  s_axis_tuser,
	// timer_id[3:0], delay[35:4], payload[67:36], destination[71:68]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind[2:0]
	output logic [2:0]  m_axis_tuser,
	// slot[3:0], fired_data[35:4], fired_destination[39:36]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	stp_pkg::state_t state_q;
	logic [31:0] tick_q, next_q;
	logic [CW-1:0] count_q, idx_q, nfire_q;
	logic [IW-1:0] sorted_q [NUM_TIMERS];
	logic [1:0]  flags_q [NUM_TIMERS];
	logic [31:0] dl_q [NUM_TIMERS];
	logic [31:0] pay_q [NUM_TIMERS];
	logic [3:0]  dst_q [NUM_TIMERS];
	logic [IW-1:0] id_q;
	logic [31:0] arm_dl_q;

	logic        ov_q, olast_q;
	logic [2:0]  okind_q;
	logic [3:0]  oslot_q, odst_q;
	logic [31:0] odata_q;

	// fired word held back until it is known whether another one follows
	logic [3:0]  pslot_q, pdst_q;
	logic [31:0] pdata_q;

	logic [2:0]  in_mode;
	logic [3:0]  in_id;
	logic [IW-1:0] in_idx;
	logic [31:0] in_delay, in_pay;
	logic [3:0]  in_dst;
	logic        id_ok;
	assign in_mode  = s_axis_tuser;
	assign in_id    = s_axis_tdata[3:0];
	assign in_idx   = IW'(in_id);
	assign in_delay = s_axis_tdata[35:4];
	assign in_pay   = s_axis_tdata[67:36];
	assign in_dst   = s_axis_tdata[71:68];
	assign id_ok    = 32'(in_id) < 32'(NUM_TIMERS);

	// shared unit: entry at idx_q, its deadline, and one compare
	logic [IW-1:0] cur_slot;
	logic [31:0]   cur_dl, cmp_ref;
	logic          cmp_gt, idx_in;
	assign idx_in   = idx_q < count_q;
	assign cur_slot = sorted_q[idx_q[IW-1:0] & {IW{idx_in}}];
	assign cur_dl   = dl_q[cur_slot];
	assign cmp_ref  = (state_q == stp_pkg::ST_FIND) ? arm_dl_q : tick_q;
	assign cmp_gt   = (state_q == stp_pkg::ST_FIND) ? (cur_dl >= cmp_ref)
		: (cur_dl > cmp_ref);

	logic out_free;
	assign out_free = !ov_q || m_axis_tready;
	assign s_axis_tready = (state_q == stp_pkg::ST_IDLE) && out_free;

	logic [31:0] head_dl_next;

	always_ff @(posedge clk or negedge arst_n) begin
		logic ov_set;
		if (!arst_n) begin
			state_q <= stp_pkg::ST_IDLE;
			tick_q  <= '0;
			next_q  <= stp_pkg::NO_DEADLINE;
			count_q <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) flags_q[i] <= stp_pkg::FLAG_FREE;
		end else begin
			ov_set = 1'b0;
			unique case (state_q)
				stp_pkg::ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						id_q    <= in_idx;
						oslot_q <= in_id;
						odata_q <= '0;
						odst_q  <= '0;
						olast_q <= 1'b1;
						idx_q   <= '0;
						unique case (in_mode)
							stp_pkg::MODE_TICK: begin
								tick_q  <= tick_q + 32'd1;
								nfire_q <= '0;
								if (next_q <= tick_q + 32'd1) state_q <= stp_pkg::ST_FIRE;
							end
							stp_pkg::MODE_ALLOC: state_q <= stp_pkg::ST_ALLOC;
							stp_pkg::MODE_FREE: begin
								if (id_ok) flags_q[in_idx] <= stp_pkg::FLAG_FREE;
								okind_q <= stp_pkg::KIND_DONE;
								ov_set = 1'b1;
							end
							stp_pkg::MODE_SET: begin
								if (id_ok) begin
									pay_q[in_idx] <= in_pay;
									dst_q[in_idx] <= in_dst;
								end
								okind_q <= stp_pkg::KIND_DONE;
								ov_set = 1'b1;
							end
							stp_pkg::MODE_ARM: begin
								if (!id_ok) begin
									okind_q <= stp_pkg::KIND_DONE;
									ov_set = 1'b1;
								end else if (32'(count_q) >= 32'(NUM_TIMERS)) begin
									okind_q <= stp_pkg::KIND_FULL;
									ov_set = 1'b1;
								end else begin
									okind_q <= stp_pkg::KIND_DONE;
									arm_dl_q <= tick_q + in_delay;
									dl_q[in_idx] <= tick_q + in_delay;
									flags_q[in_idx] <= stp_pkg::FLAG_RUN;
									state_q <= stp_pkg::ST_FIND;
								end
							end
							default: ;
						endcase
					end
				end
				stp_pkg::ST_ALLOC: begin
					// one slot a cycle, first free wins
					if (flags_q[idx_q[IW-1:0]] == stp_pkg::FLAG_FREE) begin
						flags_q[idx_q[IW-1:0]] <= stp_pkg::FLAG_ALLOC;
						okind_q <= stp_pkg::KIND_ALLOC;
						oslot_q <= 4'(idx_q[IW-1:0]);
						ov_set = 1'b1;
						state_q <= stp_pkg::ST_IDLE;
					end else if (32'(idx_q) == NUM_TIMERS - 1) begin
						okind_q <= stp_pkg::KIND_NONE;
						oslot_q <= '0;
						ov_set = 1'b1;
						state_q <= stp_pkg::ST_IDLE;
					end else idx_q <= idx_q + 1'b1;
				end
				stp_pkg::ST_FIRE: begin
					// idx_q counts fired heads; a nonzero count means a word is held back
					if (!idx_in || cmp_gt || 32'(idx_q) >= stp_pkg::MAX_FIRE) begin
						if (idx_q == '0 || out_free) begin
							if (idx_q != '0) begin
								okind_q <= stp_pkg::KIND_FIRED;
								oslot_q <= pslot_q;
								odata_q <= pdata_q;
								odst_q  <= pdst_q;
								olast_q <= 1'b1;
								ov_set = 1'b1;
							end
							nfire_q <= idx_q;
							count_q <= count_q - idx_q;
							idx_q   <= '0;
							state_q <= stp_pkg::ST_SHIFT;
						end
					end else if (idx_q == '0 || out_free) begin
						if (idx_q != '0) begin
							okind_q <= stp_pkg::KIND_FIRED;
							oslot_q <= pslot_q;
							odata_q <= pdata_q;
							odst_q  <= pdst_q;
							olast_q <= 1'b0;
							ov_set = 1'b1;
						end
						flags_q[cur_slot] <= stp_pkg::FLAG_ALLOC;
						pslot_q <= 4'(cur_slot);
						pdata_q <= pay_q[cur_slot];
						pdst_q  <= dst_q[cur_slot];
						idx_q   <= idx_q + 1'b1;
					end
				end
				stp_pkg::ST_SHIFT: begin
					if (idx_q < count_q) begin
						sorted_q[idx_q[IW-1:0]] <= sorted_q[IW'(idx_q + nfire_q)];
						idx_q <= idx_q + 1'b1;
					end else begin
						next_q  <= (count_q != '0) ? head_dl_next : stp_pkg::NO_DEADLINE;
						state_q <= stp_pkg::ST_OUT;
					end
				end
				stp_pkg::ST_FIND: begin
					if (!idx_in || cmp_gt) begin
						nfire_q <= count_q;
						state_q <= stp_pkg::ST_INSERT;
					end else idx_q <= idx_q + 1'b1;
				end
				stp_pkg::ST_INSERT: begin
					// nfire_q walks down from the tail to the insert point
					if (nfire_q > idx_q) begin
						sorted_q[nfire_q[IW-1:0]] <= sorted_q[IW'(nfire_q - 1'b1)];
						nfire_q <= nfire_q - 1'b1;
					end else begin
						sorted_q[idx_q[IW-1:0]] <= id_q;
						count_q <= count_q + 1'b1;
						next_q  <= (idx_q == '0) ? arm_dl_q : next_q;
						ov_set = 1'b1;
						state_q <= stp_pkg::ST_IDLE;
					end
				end
				stp_pkg::ST_OUT: state_q <= stp_pkg::ST_IDLE;
				default: state_q <= stp_pkg::ST_IDLE;
			endcase
			ov_q <= ov_set || (ov_q && !m_axis_tready);
		end
	end

	assign head_dl_next = dl_q[sorted_q[0]];

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tdata  = {odst_q, odata_q, oslot_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == stp_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= NUM_TIMERS)
		else $error("list overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_axis_tready |=> ov_q && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word dropped");
endmodule

>>> sim/testbench.sv
// self-checking testbench for sorted_timeout_timer_pool_unit
// depends on stp_pkg and the unit; predicts every result word and compares
module testbench;

	localparam int NT = 16;
	localparam int WATCHDOG = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [31:0] data;
		logic [3:0]  dest;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [2:0]  s_axis_tuser;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [2:0]  m_axis_tuser;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	sorted_timeout_timer_pool_unit #(.NUM_TIMERS(NT)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// timer pool shadow
	logic [31:0] now;
	logic [4:0]  n_running;
	logic [3:0]  order [NT];
	logic [1:0]  flags [NT];
	logic [31:0] due [NT];
	logic [31:0] pay [NT];
	logic [3:0]  dst [NT];

	// items are mode[2:0], timer_id[6:3], delay[38:7], payload[70:39], destination[74:71]
	logic [74:0] pending_words [$];
	result_t     expected_results [$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 0;
	bit          hold_seen;
	int          hold_left;
	int          quiet = 0;
	// stimulus-side shadow to keep reads of unwritten stores impossible
	bit          data_set [NT];

	function automatic result_t mk(logic [2:0] k, logic [3:0] s, logic [31:0] d,
			logic [3:0] t, logic l);
		result_t r;
		r.kind = k; r.slot = s; r.data = d; r.dest = t; r.last = l;
		return r;
	endfunction

	task automatic predict_word(input logic [74:0] w);
		logic [2:0]  mode;
		logic [3:0]  id;
		logic [31:0] dly;
		logic [31:0] dl;
		int          n, i, j;
		logic [3:0]  s;
		bit          found;
		mode = w[2:0]; id = w[6:3]; dly = w[38:7];
		case (mode)
			stp_pkg::MODE_TICK: begin
				now = now + 32'd1;
				n = 0;
				if (!(n_running > 0 && due[order[0]] > now) && n_running > 0) begin
					while (n < n_running && n < stp_pkg::MAX_FIRE && due[order[n]] <= now) begin
						s = order[n];
						flags[s] = stp_pkg::FLAG_ALLOC;
						expected_results.push_back(mk(stp_pkg::KIND_FIRED, s, pay[s], dst[s],
							(n + 1 == n_running) || (n + 1 == stp_pkg::MAX_FIRE)
							|| due[order[n + 1]] > now));
						n++;
					end
					n_running = 5'(n_running - n);
					for (j = 0; j < n_running; j++)
						order[j] = order[j + n];
				end
			end
			stp_pkg::MODE_ALLOC: begin
				found = 0;
				for (i = 0; i < NT; i++) begin
					if (!found && flags[i] == stp_pkg::FLAG_FREE) begin
						flags[i] = stp_pkg::FLAG_ALLOC;
						expected_results.push_back(mk(stp_pkg::KIND_ALLOC, 4'(i), '0, '0, 1'b1));
						found = 1;
					end
				end
				if (!found)
					expected_results.push_back(mk(stp_pkg::KIND_NONE, '0, '0, '0, 1'b1));
			end
			stp_pkg::MODE_FREE: begin
				flags[id] = stp_pkg::FLAG_FREE;
				expected_results.push_back(mk(stp_pkg::KIND_DONE, id, '0, '0, 1'b1));
			end
			stp_pkg::MODE_SET: begin
				pay[id] = w[70:39];
				dst[id] = w[74:71];
				expected_results.push_back(mk(stp_pkg::KIND_DONE, id, '0, '0, 1'b1));
			end
			stp_pkg::MODE_ARM: begin
				if (n_running >= NT) begin
					expected_results.push_back(mk(stp_pkg::KIND_FULL, id, '0, '0, 1'b1));
				end else begin
					dl = now + dly;
					due[id] = dl;
					flags[id] = stp_pkg::FLAG_RUN;
					i = 0;
					while (i < n_running && due[order[i]] < dl)
						i++;
					for (j = n_running; j > i; j--)
						order[j] = order[j - 1];
					order[i] = id;
					n_running++;
					expected_results.push_back(mk(stp_pkg::KIND_DONE, id, '0, '0, 1'b1));
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [74:0] pack_word(logic [2:0] m, logic [3:0] id,
			logic [31:0] d, logic [31:0] p, logic [3:0] t);
		return {t, p, d, id, m};
	endfunction

	// arm only timers whose payload was set, so a firing never reads an unwritten slot
	task automatic queue_word(input logic [74:0] w);
		if (w[2:0] == stp_pkg::MODE_SET)
			data_set[w[6:3]] = 1;
		if (w[2:0] == stp_pkg::MODE_ARM && !data_set[w[6:3]])
			return;
		pending_words.push_back(w);
	endtask

	always begin
		clk = 1; #10;
		clk = 0; #10;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic [74:0] w;
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tuser <= '0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_word({s_axis_tdata, s_axis_tuser});
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = pending_words.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tuser <= w[2:0];
				s_axis_tdata <= w[74:3];
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_seen) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = mk(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4],
					m_axis_tdata[39:36], m_axis_tlast);
				if (expected_results.size() == 0) begin
					$error("unexpected word kind=%0d slot=%0d", got.kind, got.slot);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, got.kind);
						errors++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, got.slot);
						errors++;
					end
					if (got.data !== want.data) begin
						$error("fired_data: expected %0h, actual %0h", want.data, got.data);
						errors++;
					end
					if (got.dest !== want.dest) begin
						$error("fired_destination: expected %0d, actual %0d", want.dest,
							got.dest);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, got.last);
						errors++;
					end
				end
			end
			m_axis_tready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("** sorted_timeout_timer_pool_unit: FAILED **");
			$finish;
		end
	end

	task automatic drain;
		while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int idle, input int stall);
		int          k, id;
		logic [31:0] d;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (k = 0; k < count; k++) begin
			id = $urandom_range(NT - 1);
			case ($urandom_range(9))
				0, 1, 2: queue_word(pack_word(stp_pkg::MODE_TICK, 4'($urandom), $urandom,
					$urandom, 4'($urandom)));
				3: queue_word(pack_word(stp_pkg::MODE_ALLOC, 4'($urandom), $urandom,
					$urandom, 4'($urandom)));
				4: queue_word(pack_word(stp_pkg::MODE_FREE, 4'(id), $urandom, $urandom,
					4'($urandom)));
				5: queue_word(pack_word(stp_pkg::MODE_SET, 4'(id), $urandom, $urandom,
					4'($urandom)));
				6, 7, 8: begin
					// mostly short delays so timers expire within the run
					d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
					queue_word(pack_word(stp_pkg::MODE_ARM, 4'(id), d, $urandom,
						4'($urandom)));
				end
				default: queue_word(pack_word(3'(5 + $urandom_range(2)), 4'($urandom),
					$urandom, $urandom, 4'($urandom)));
			endcase
		end
		drain();
	endtask

	initial begin
		int i;
		now = 0;
		n_running = 0;
		for (i = 0; i < NT; i++) begin
			flags[i] = stp_pkg::FLAG_FREE;
			data_set[i] = 0;
		end
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: allocate all plus one, set extremes, arm equal deadlines, fire
		for (i = 0; i < NT + 1; i++)
			queue_word(pack_word(stp_pkg::MODE_ALLOC, '0, '0, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_SET, 4'd0, '0, 32'h8000_0000, 4'hf));
		queue_word(pack_word(stp_pkg::MODE_SET, 4'd15, '1, 32'h7fff_ffff, 4'h0));
		queue_word(pack_word(stp_pkg::MODE_SET, 4'd1, '0, 32'hffff_ffff, 4'h5));
		queue_word(pack_word(stp_pkg::MODE_ARM, 4'd0, 32'd2, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_ARM, 4'd15, 32'd2, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_ARM, 4'd0, 32'd1, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_ARM, 4'd1, 32'hffff_ffff, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_FREE, 4'd15, '0, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_TICK, '0, '0, '0, '0));
		queue_word(pack_word(stp_pkg::MODE_TICK, '0, '0, '0, '0));
		queue_word(pack_word(3'd7, 4'hf, '1, '1, 4'hf));
		queue_word(pack_word(stp_pkg::MODE_TICK, '0, '0, '0, '0));
		drain();
		// full list: seventeen arms onto a list that still holds one entry; the last two are refused
		for (i = 0; i < NT + 1; i++)
			queue_word(pack_word(stp_pkg::MODE_ARM, 4'd0, 32'd5, '0, '0));
		drain();
		repeat (6) queue_word(pack_word(stp_pkg::MODE_TICK, '0, '0, '0, '0));
		drain();

		random_phase(80, 0, 0);
		random_phase(60, 88, 0);
		random_phase(60, 0, 88);
		random_phase(60, 7, 7);

		// long receiver hold-off while the sender keeps offering
		hold_req = 1;
		for (i = 0; i < 20; i++)
			queue_word(pack_word(stp_pkg::MODE_ALLOC, '0, '0, '0, '0));
		wait (hold_seen && hold_left == 0);
		hold_req = 0;
		random_phase(40, 0, 0);

		repeat (2 * NT + 20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("** sorted_timeout_timer_pool_unit: PASSED **");
		else
			$display("** sorted_timeout_timer_pool_unit: FAILED **");
		$finish;
	end

endmodule
